// ===== rtl/plr_pkg.sv =====
// Shared types and constants for the permutation rank unit.
// Used by plr_cell, plr_accum and permutation_lexicographic_rank_unit.
package plr_pkg;

  localparam int ELEM_W        = 16;
  localparam int DIGIT_W       = 5;
  localparam int RANK_W        = 45;
  localparam int MAX_ELEMS_DEF = 16;

  typedef logic [ELEM_W-1:0]  elem_t;
  typedef logic [DIGIT_W-1:0] digit_t;
  typedef logic [RANK_W-1:0]  rank_t;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SUM  = 3'b010,
    ST_FIN  = 3'b100
  } state_t;

  typedef struct packed {
    logic load;
    logic shift;
  } cell_ctl_t;

  typedef struct packed {
    logic clr;
    logic step;
  } acc_ctl_t;

endpackage

// ===== rtl/plr_cell.sv =====
// One cell of the element chain: holds one element and its Lehmer digit.
// Depends on plr_pkg.
module plr_cell import plr_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  cell_ctl_t ctl,
  input  logic      occ,
  input  elem_t     new_value,
  input  elem_t     elem_in,
  input  digit_t    dig_in,
  output elem_t     elem_out,
  output digit_t    dig_out
);

  elem_t  elem_r;
  digit_t dig_r;
  logic   inc;

  assign inc      = ctl.load & occ & (new_value < elem_r);
  assign dig_out  = dig_r + DIGIT_W'(inc);
  assign elem_out = elem_r;

  always_ff @(posedge clk) begin
    if (ctl.shift) begin
      elem_r <= elem_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dig_r <= '0;
    end else if (ctl.shift) begin
      dig_r <= dig_in;
    end
  end

endmodule

// ===== rtl/plr_accum.sv =====
// Mixed-radix accumulator: while step is set, folds one digit per cycle, acc = acc * factor + digit.
// Depends on plr_pkg.
module plr_accum import plr_pkg::*; #(
  parameter int CNT_W = 5
) (
  input  logic             clk,
  input  acc_ctl_t         ctl,
  input  logic [CNT_W-1:0] factor,
  input  digit_t           digit,
  output rank_t            acc
);

  rank_t                    acc_r;
  rank_t                    acc_nxt;
  logic [RANK_W+CNT_W-1:0]  prod;

  assign prod    = acc_r * factor;
  assign acc_nxt = prod[RANK_W-1:0] + RANK_W'(digit);
  assign acc     = acc_r;

  always_ff @(posedge clk) begin
    if (ctl.clr) begin
      acc_r <= '0;
    end else if (ctl.step) begin
      acc_r <= acc_nxt;
    end
  end

endmodule

// ===== rtl/permutation_lexicographic_rank_unit.sv =====
// Top level of the permutation rank unit: element chain, sequencer, result register.
// Depends on plr_pkg, plr_cell and plr_accum.
//
//   port group   dir   payload                      handshake
//   in_          in    elem_value, last_element     in_valid / in_stall
//   out_         out   rank, overflow               out_valid / out_stall
//
// While the chain is not full, all chain cells compare each element at once and shift.
// After the final element, the accumulator folds one digit per cycle from the
// chain's far end, one per cell; the final step then adds one and registers.
// Input stalls until the result is registered; a new sequence waits for the last one.
// Reset clears digits, counters and handshake state; elements are not reset.
// A waiting result does not block loading; only the final step waits on out_stall.
module permutation_lexicographic_rank_unit import plr_pkg::*; #(
  parameter int MAX_ELEMS = MAX_ELEMS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [ELEM_W-1:0] in_elem_value,
  input  logic              in_last_element,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [RANK_W-1:0] out_rank,
  output logic              out_overflow
);

  localparam int CNT_W = $clog2(MAX_ELEMS + 1);

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [CNT_W-1:0] step_r, step_nxt;
  logic             ovf_r, ovf_nxt;
  logic             out_valid_r, out_valid_nxt;
  rank_t            out_rank_r;
  logic             out_ovf_r;

  logic             in_acc;
  logic             full;
  logic             out_load;
  cell_ctl_t        cell_ctl;
  acc_ctl_t         acc_ctl;
  rank_t            acc;
  logic [CNT_W-1:0] factor;

  elem_t            e_link [MAX_ELEMS+1];
  digit_t           d_link [MAX_ELEMS+1];
  logic [MAX_ELEMS-1:0] occ;

  assign in_stall = (state_r != ST_IDLE);
  assign in_acc   = in_valid & ~in_stall;
  assign full     = (count_r == CNT_W'(MAX_ELEMS));

  assign cell_ctl.load  = in_acc & ~full;
  assign cell_ctl.shift = cell_ctl.load | (state_r == ST_SUM);

  assign e_link[0] = in_elem_value;
  assign d_link[0] = '0;

  for (genvar i = 0; i < MAX_ELEMS; i++) begin : g_cell
    assign occ[i] = (CNT_W'(i) < count_r);
    plr_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctl       (cell_ctl),
      .occ       (occ[i]),
      .new_value (in_elem_value),
      .elem_in   (e_link[i]),
      .dig_in    (d_link[i]),
      .elem_out  (e_link[i+1]),
      .dig_out   (d_link[i+1])
    );
  end

  assign acc_ctl.clr  = in_acc & in_last_element;
  assign acc_ctl.step = (state_r == ST_SUM);
  assign factor       = step_r + CNT_W'(1);

  plr_accum #(.CNT_W(CNT_W)) u_accum (
    .clk    (clk),
    .ctl    (acc_ctl),
    .factor (factor),
    .digit  (d_link[MAX_ELEMS]),
    .acc    (acc)
  );

  assign out_load = (state_r == ST_FIN) & (~out_valid_r | ~out_stall);

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    step_nxt      = step_r;
    ovf_nxt       = ovf_r;
    out_valid_nxt = out_valid_r & out_stall;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (full) begin
            ovf_nxt = 1'b1;
          end else begin
            count_nxt = count_r + CNT_W'(1);
          end
          if (in_last_element) begin
            step_nxt  = CNT_W'(MAX_ELEMS - 1);
            state_nxt = ST_SUM;
          end
        end
      end
      ST_SUM: begin
        if (step_r == '0) begin
          state_nxt = ST_FIN;
        end else begin
          step_nxt = step_r - CNT_W'(1);
        end
      end
      ST_FIN: begin
        if (out_load) begin
          out_valid_nxt = 1'b1;
          count_nxt     = '0;
          ovf_nxt       = 1'b0;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      step_r      <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      step_r      <= step_nxt;
      ovf_r       <= ovf_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_rank_r <= acc + RANK_W'(1);
      out_ovf_r  <= ovf_r;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_rank     = out_rank_r;
  assign out_overflow = out_ovf_r;

endmodule

// ===== tb/permutation_lexicographic_rank_unit_tb.sv =====
// Testbench for permutation_lexicographic_rank_unit: drives element sequences and
// checks each rank and overflow flag against a Lehmer-code predictor kept here.
// Depends on plr_pkg and the permutation_lexicographic_rank_unit RTL.
module permutation_lexicographic_rank_unit_tb;
  import plr_pkg::*;

  typedef struct {
    rank_t rank;
    logic  overflow;
  } rank_result_t;

  logic  clk = 1'b0;
  logic  rst_n = 1'b0;
  logic  in_valid = 1'b0;
  logic  in_stall;
  elem_t in_elem_value = '0;
  logic  in_last_element = 1'b0;
  logic  out_valid;
  logic  out_stall = 1'b0;
  rank_t out_rank;
  logic  out_overflow;

  elem_t        seq_elems [MAX_ELEMS_DEF];
  digit_t       seq_digits [MAX_ELEMS_DEF];
  int           seq_len = 0;
  logic         seq_overflow = 1'b0;
  rank_result_t pending_ranks [$];

  int errors = 0;
  int requests_sent = 0;
  int idle_pct = 38;
  int hold_cycles = 0;

  permutation_lexicographic_rank_unit dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_elem_value   (in_elem_value),
    .in_last_element (in_last_element),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_rank        (out_rank),
    .out_overflow    (out_overflow)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic rank_t lex_rank();
    logic [63:0] sum;
    logic [63:0] fact;
    int          k;
    sum = 64'd1;
    fact = 64'd1;
    for (k = 0; k < seq_len; k++) begin
      if (k > 0) fact = fact * k;
      sum = sum + seq_digits[seq_len-1-k] * fact;
    end
    return sum[RANK_W-1:0];
  endfunction

  function automatic void absorb_element(elem_t v, logic last);
    rank_result_t res;
    int           j;
    if (seq_len < MAX_ELEMS_DEF) begin
      for (j = 0; j < seq_len; j++)
        if (v < seq_elems[j]) seq_digits[j] = seq_digits[j] + 1'b1;
      seq_elems[seq_len] = v;
      seq_digits[seq_len] = '0;
      seq_len++;
    end else begin
      seq_overflow = 1'b1;
    end
    if (last) begin
      res.rank = lex_rank();
      res.overflow = seq_overflow;
      pending_ranks.push_back(res);
      for (j = 0; j < MAX_ELEMS_DEF; j++) seq_digits[j] = '0;
      seq_len = 0;
      seq_overflow = 1'b0;
    end
  endfunction

  always @(posedge clk) begin
    rank_result_t want;
    if (rst_n && in_valid && !in_stall) absorb_element(in_elem_value, in_last_element);
    if (rst_n && out_valid && !out_stall) begin
      if (pending_ranks.size() == 0) begin
        errors++;
        $display("%0t unexpected result rank %0d overflow %0b", $time, out_rank,
                 out_overflow);
      end else begin
        want = pending_ranks.pop_front();
        if (out_rank !== want.rank) begin
          errors++;
          $display("%0t rank expected %0d actual %0d", $time, want.rank, out_rank);
        end
        if (out_overflow !== want.overflow) begin
          errors++;
          $display("%0t overflow expected %0b actual %0b", $time, want.overflow,
                   out_overflow);
        end
      end
    end
  end

  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      out_stall <= 1'b1;
      hold_cycles = hold_cycles - 1;
    end else begin
      out_stall <= ($urandom_range(99) < idle_pct);
    end
  end

  task automatic send_elem(input elem_t v, input logic last);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_elem_value <= v;
    in_last_element <= last;
    do @(posedge clk); while (in_stall);
    requests_sent++;
    @(negedge clk);
  endtask

  task automatic send_sequence(input int len, input int span);
    elem_t base;
    int    k;
    base = elem_t'($urandom_range(65535));
    for (k = 0; k < len; k++)
      send_elem(base + elem_t'($urandom_range(span)), k == len - 1);
  endtask

  task automatic send_random_sequence();
    int len;
    int pick;
    pick = $urandom_range(99);
    if (pick < 75) len = $urandom_range(16, 1);
    else if (pick < 90) len = MAX_ELEMS_DEF;
    else len = $urandom_range(MAX_ELEMS_DEF + 4, MAX_ELEMS_DEF + 1);
    case ($urandom_range(2))
      0: send_sequence(len, 3);
      1: send_sequence(len, 40);
      default: send_sequence(len, 65535);
    endcase
  endtask

  task automatic test_single_element();
    send_elem(16'hFFFF, 1'b1);
    send_elem(16'h0000, 1'b1);
  endtask

  task automatic test_equal_values();
    send_elem(16'h0000, 1'b0);
    send_elem(16'h0000, 1'b1);
  endtask

  // descending fill gives the largest rank; drop the last two, final included
  task automatic test_overflow_descending();
    int k;
    for (k = 0; k < MAX_ELEMS_DEF; k++)
      send_elem(elem_t'((MAX_ELEMS_DEF - 1 - k) * 4369), 1'b0);
    send_elem(16'h0007, 1'b0);
    send_elem(16'hFFFF, 1'b1);
  endtask

  task automatic test_no_idle();
    idle_pct = 0;
    while (requests_sent < 330) send_random_sequence();
    idle_pct = 38;
  endtask

  task automatic test_backpressure();
    idle_pct = 0;
    hold_cycles = 400;
    while (requests_sent < 460) send_random_sequence();
    idle_pct = 38;
  endtask

  task automatic test_random();
    while (requests_sent < 1600) send_random_sequence();
  endtask

  initial begin
    int waited;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_single_element();
    test_equal_values();
    test_overflow_descending();
    test_no_idle();
    test_backpressure();
    test_random();
    in_valid <= 1'b0;
    waited = 0;
    while (pending_ranks.size() != 0 && waited < 20000) begin
      @(posedge clk);
      waited++;
    end
    if (pending_ranks.size() != 0) begin
      errors++;
      $display("%0t %0d results never arrived", $time, pending_ranks.size());
    end
    repeat (2 * MAX_ELEMS_DEF + 8) @(posedge clk);
    if (errors == 0)
      $display("[permutation_lexicographic_rank_unit] OK");
    else
      $display("[permutation_lexicographic_rank_unit] ERROR");
    $finish;
  end

  initial begin
    #4000000;
    $display("[permutation_lexicographic_rank_unit] ERROR");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/plr_pkg.sv
rtl/plr_cell.sv
rtl/plr_accum.sv
rtl/permutation_lexicographic_rank_unit.sv
tb/permutation_lexicographic_rank_unit_tb.sv
